// ===== sv/tpcu_pkg.sv =====
// Shared widths, codes and the note translation for the pattern cell unpacker.
`default_nettype none
package tpcu_pkg;

   localparam int ByteW   = 8;
   localparam int VolumeW = 9;
   localparam int RowW    = 8;
   localparam int ColumnW = 6;
   localparam int ChanCfgW = 7;
   localparam int RowCfgW  = 9;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 9;
   localparam int MaskW    = 5;

   localparam int DefMaxChannels = 64;
   localparam int DefMaxRows     = 256;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_CHANNEL_COUNT = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_ROW_COUNT     = 1'd1;

   localparam logic [ChanCfgW-1:0] CHAN_CFG_RESET = 7'd4;
   localparam logic [RowCfgW-1:0]  ROW_CFG_RESET  = 9'd64;

   localparam logic [ByteW-1:0] NOTE_NONE     = 8'd255;
   localparam logic [ByteW-1:0] NOTE_OFF      = 8'd120;
   localparam logic [6:0]       NOTE_OFF_CODE = 7'h61;
   localparam logic [ByteW-1:0] INST_NONE     = 8'd255;
   localparam logic [ByteW-1:0] MACHINE_EMPTY = 8'd255;
   localparam logic [ByteW-1:0] VOL_LOW       = 8'h10;
   localparam logic [ByteW-1:0] VOL_HIGH      = 8'h50;
   localparam logic [MaskW-1:0] MASK_ALL_BUT_NOTE = 5'h1e;

   // Map a raw note byte to the output note code.
   function automatic logic [ByteW-1:0] translate_note(input logic [ByteW-1:0] raw);
      logic [ByteW-1:0] n;
      n = {1'b0, raw[6:0]};
      if (n == '0)                          return NOTE_NONE;
      else if (n[6:0] == NOTE_OFF_CODE)     return NOTE_OFF;
      else if (n >= 8'd30)                  return n - 8'd30;
      else if (n >= 8'd18)                  return n - 8'd18;
      else if (n >= 8'd6)                   return n - 8'd6;
      else                                  return n + 8'd6;
   endfunction

endpackage
`default_nettype wire

// ===== sv/tpcu_ifs.sv =====
// Channel interfaces: packed byte input, unpacked cell output, register write port.
`default_nettype none
interface tpcu_req_if import tpcu_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tpcu_rsp_if import tpcu_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [ByteW-1:0]   note;
   logic [ByteW-1:0]   instrument;
   logic [ByteW-1:0]   machine;
   logic [VolumeW-1:0] volume;
   logic [ByteW-1:0]   effect_command;
   logic [ByteW-1:0]   effect_parameter;
   logic [RowW-1:0]    row;
   logic [ColumnW-1:0] column;
   logic               last_in_pattern;
   modport source (output valid, output note, output instrument, output machine,
                   output volume, output effect_command, output effect_parameter,
                   output row, output column, output last_in_pattern, input ready);
   modport sink   (input valid, input note, input instrument, input machine,
                   input volume, input effect_command, input effect_parameter,
                   input row, input column, input last_in_pattern, output ready);
endinterface

interface tpcu_csr_if import tpcu_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/tracker_pattern_cell_unpacker.sv =====
// Top level: packed pattern byte stream to one translated entry per cell.
// Usage
//   req_bus : one packed pattern byte per word. A cell starts with either a
//             mask byte (bit 7 set, bits 0..4 flag note, instrument, volume,
//             command, parameter) or a plain note byte (all four others follow).
//   rsp_bus : one word per completed cell, tagged with row, column and a
//             last-in-pattern flag. Bytes that do not finish a cell give none.
//   csr_bus : index 0 writes channel_count, index 1 writes row_count. Always
//             ready; write only while no cell is partly received or pending.
// Timing
//   A byte is taken every cycle while the output is not stalled. The byte
//   that completes a cell loads the output register at the edge that takes
//   it, so its entry can be taken in the next cycle.
// Reset
//   Synchronous, active high: counters at row 0 column 0, no partial cell,
//   registers back to 4 channels and 64 rows, output empty.
// Stall
//   While the output word waits, req_bus stays ready only if it is taken in
//   the same cycle; otherwise input bytes hold.
`default_nettype none
module tracker_pattern_cell_unpacker import tpcu_pkg::*; #(
   parameter int MAX_CHANNELS = DefMaxChannels,
   parameter int MAX_ROWS     = DefMaxRows
) (
   input  wire logic    clock,
   input  wire logic    reset,
   tpcu_req_if.sink     req_bus,
   tpcu_rsp_if.source   rsp_bus,
   tpcu_csr_if.sink     csr_bus
);

   // configuration
   logic [ChanCfgW-1:0] chan_cfg_ff;
   logic [RowCfgW-1:0]  row_cfg_ff;

   // cell assembly state; a nonzero mask means a cell is in progress
   logic [MaskW-1:0]   mask_ff, mask_in;
   logic [ByteW-1:0]   note_ff, note_in;
   logic [ByteW-1:0]   inst_ff, inst_in;
   logic [ByteW-1:0]   vol_ff, vol_in;
   logic [ByteW-1:0]   cmd_ff, cmd_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic [ColumnW-1:0] col_ff, col_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0]   o_note_ff, o_inst_ff, o_mach_ff, o_cmd_ff, o_param_ff;
   logic [VolumeW-1:0] o_vol_ff;
   logic [RowW-1:0]    o_row_ff;
   logic [ColumnW-1:0] o_col_ff;
   logic               o_last_ff;

   logic               req_fire;
   logic               first_byte;
   logic               emit;
   logic [ByteW-1:0]   b;
   logic [ByteW-1:0]   param;
   logic [ByteW-1:0]   note_t;
   logic [ByteW-1:0]   inst_t;
   logic [VolumeW-1:0] vol_t;
   logic [6:0]         vol_off;
   logic [ByteW-1:0]   mach_t;
   logic               last_t;
   logic [ChanCfgW-1:0] chans;
   logic [RowCfgW-1:0]  rows;
   logic [ChanCfgW-1:0] col_next;
   logic [RowCfgW-1:0]  row_next;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign first_byte    = (mask_ff == '0);

   // clamp the configured limits into 1..MAX
   always_comb begin
      if (chan_cfg_ff == '0)                          chans = ChanCfgW'(1);
      else if (chan_cfg_ff > ChanCfgW'(MAX_CHANNELS)) chans = ChanCfgW'(MAX_CHANNELS);
      else                                            chans = chan_cfg_ff;
      if (row_cfg_ff == '0)                           rows = RowCfgW'(1);
      else if (row_cfg_ff > RowCfgW'(MAX_ROWS))       rows = RowCfgW'(MAX_ROWS);
      else                                            rows = row_cfg_ff;
   end

   // field capture: first byte opens a cell, later bytes fill in flag order
   always_comb begin
      mask_in = mask_ff;
      note_in = note_ff;
      inst_in = inst_ff;
      vol_in  = vol_ff;
      cmd_in  = cmd_ff;
      param   = '0;
      if (first_byte) begin
         inst_in = INST_NONE;
         vol_in  = '0;
         cmd_in  = '0;
         if (b[7]) begin
            note_in = '0;
            mask_in = b[MaskW-1:0];
         end else begin
            note_in = b;
            mask_in = MASK_ALL_BUT_NOTE;
         end
      end else if (mask_ff[0]) begin
         note_in    = b;
         mask_in[0] = 1'b0;
      end else if (mask_ff[1]) begin
         inst_in    = b;
         mask_in[1] = 1'b0;
      end else if (mask_ff[2]) begin
         vol_in     = b;
         mask_in[2] = 1'b0;
      end else if (mask_ff[3]) begin
         cmd_in     = b;
         mask_in[3] = 1'b0;
      end else begin
         param   = b;
         mask_in = '0;
      end
   end

   assign emit = (mask_in == '0);

   // translate the completed cell
   always_comb begin
      note_t  = translate_note(note_in);
      inst_t  = (note_t == NOTE_OFF) ? INST_NONE : inst_in;
      vol_off = 7'(vol_in - VOL_LOW);
      if (vol_in >= VOL_LOW && vol_in <= VOL_HIGH) vol_t = {vol_off, 2'b00};
      else                                         vol_t = '0;
      mach_t  = (note_t == NOTE_NONE && cmd_in == '0 && param == '0 &&
                 inst_t == INST_NONE && vol_t == '0) ? MACHINE_EMPTY : '0;
      last_t  = ({1'b0, col_ff} == chans - ChanCfgW'(1)) &&
                ({1'b0, row_ff} == rows - RowCfgW'(1));
   end

   // advance position, wrap at the end of a row and of the pattern
   always_comb begin
      col_next = {1'b0, col_ff} + ChanCfgW'(1);
      row_next = {1'b0, row_ff} + RowCfgW'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (col_next >= chans) begin
         col_in = '0;
         row_in = (row_next >= rows) ? '0 : row_next[RowW-1:0];
      end else begin
         col_in = col_next[ColumnW-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) rsp_valid_in = 1'b0;
      if (req_fire && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff  <= CHAN_CFG_RESET;
         row_cfg_ff   <= ROW_CFG_RESET;
         mask_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_CHANNEL_COUNT: chan_cfg_ff <= csr_bus.data[ChanCfgW-1:0];
               CSR_ROW_COUNT:     row_cfg_ff  <= csr_bus.data;
               default: ;
            endcase
         end
         if (req_fire) begin
            mask_ff <= mask_in;
            if (emit) begin
               row_ff <= row_in;
               col_ff <= col_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // held fields and output payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         note_ff <= note_in;
         inst_ff <= inst_in;
         vol_ff  <= vol_in;
         cmd_ff  <= cmd_in;
         if (emit) begin
            o_note_ff  <= note_t;
            o_inst_ff  <= inst_t;
            o_mach_ff  <= mach_t;
            o_vol_ff   <= vol_t;
            o_cmd_ff   <= cmd_in;
            o_param_ff <= param;
            o_row_ff   <= row_ff;
            o_col_ff   <= col_ff;
            o_last_ff  <= last_t;
         end
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.note             = o_note_ff;
   assign rsp_bus.instrument       = o_inst_ff;
   assign rsp_bus.machine          = o_mach_ff;
   assign rsp_bus.volume           = o_vol_ff;
   assign rsp_bus.effect_command   = o_cmd_ff;
   assign rsp_bus.effect_parameter = o_param_ff;
   assign rsp_bus.row              = o_row_ff;
   assign rsp_bus.column           = o_col_ff;
   assign rsp_bus.last_in_pattern  = o_last_ff;

   // the last cell of a pattern sends both counters back to the origin
   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && emit && last_t |=> row_ff == '0 && col_ff == '0)
      else $error("position did not wrap after last cell");

   // a plain note byte opens a cell expecting the four remaining fields
   a_plain_note_mask: assert property (@(posedge clock) disable iff (reset)
      req_fire && first_byte && !b[7] |=> mask_ff == MASK_ALL_BUT_NOTE)
      else $error("plain note byte did not load full field mask");

   // an empty cell carries no note, no instrument and no volume
   a_empty_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_mach_ff == MACHINE_EMPTY |->
         o_note_ff == NOTE_NONE && o_inst_ff == INST_NONE && o_vol_ff == '0)
      else $error("empty cell flag with content");

   // note-off never carries an instrument
   a_note_off_inst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_note_ff == NOTE_OFF |-> o_inst_ff == INST_NONE)
      else $error("note-off with instrument");

endmodule
`default_nettype wire

// ===== test/tracker_pattern_cell_unpacker_tb.sv =====
// Self-checking testbench for the packed pattern cell unpacker.
`default_nettype none
module tracker_pattern_cell_unpacker_tb;
   import tpcu_pkg::*;

   // Stop after this many cycles in which no word moves on any channel.
   localparam int WATCHDOG_LIMIT = 400;
   // Print at most this many mismatch lines; count all of them.
   localparam int REPORT_CAP = 40;

   // Opening cells, one byte per word:
   //   plain note 0 with a volume just below range, then an empty mask,
   //   a mask with only the ignored bits 5 and 6 set, a plain note-off,
   //   a full mask carrying every field at its top value, a lone note from
   //   the bottom of the 18 band, an out-of-range volume, a zero command
   //   that leaves the cell empty, a lone parameter and a zero instrument.
   localparam logic [ByteW-1:0] OPENING [28] = '{
      8'h00, 8'h00, 8'h0f, 8'h00, 8'h00,
      8'h80,
      8'he0,
      8'h61, 8'h05, 8'h10, 8'h0f, 8'hff,
      8'h9f, 8'hff, 8'hff, 8'h50, 8'hff, 8'hff,
      8'h81, 8'h12,
      8'h84, 8'h51,
      8'h88, 8'h00,
      8'h90, 8'h01,
      8'h82, 8'h00
   };

   typedef struct packed {
      logic [ByteW-1:0]   note;
      logic [ByteW-1:0]   instrument;
      logic [ByteW-1:0]   machine;
      logic [VolumeW-1:0] volume;
      logic [ByteW-1:0]   effect_command;
      logic [ByteW-1:0]   effect_parameter;
      logic [RowW-1:0]    row;
      logic [ColumnW-1:0] column;
      logic               last_in_pattern;
   } cell_entry_type;

   // Tracks the cell being assembled, the pattern position and the register
   // values, and holds the entries the block still owes.
   class cell_ledger_type;
      logic [ChanCfgW-1:0] chan_cfg;
      logic [RowCfgW-1:0]  row_cfg;
      bit                  mid;
      logic [MaskW-1:0]    mask;
      logic [ByteW-1:0]    note_b;
      logic [ByteW-1:0]    inst_b;
      logic [ByteW-1:0]    vol_b;
      logic [ByteW-1:0]    cmd_b;
      int                  row_ctr;
      int                  col_ctr;
      cell_entry_type      due_cells [$];
      int                  errors;

      function new();
         chan_cfg = CHAN_CFG_RESET;
         row_cfg  = ROW_CFG_RESET;
         mid      = 1'b0;
         mask     = '0;
         note_b   = '0;
         inst_b   = INST_NONE;
         vol_b    = '0;
         cmd_b    = '0;
         row_ctr  = 0;
         col_ctr  = 0;
         errors   = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
         if (idx == CSR_CHANNEL_COUNT) begin
            chan_cfg = val[ChanCfgW-1:0];
         end else begin
            row_cfg = val[RowCfgW-1:0];
         end
      endfunction

      // Advance the cell assembly by one accepted byte; queue an entry when
      // the byte completes the cell.
      function void take_byte(logic [ByteW-1:0] b);
         logic [ByteW-1:0] param;
         logic [ByteW-1:0] note_out;
         logic [ByteW-1:0] inst_out;
         int               vol_out;
         int               chans;
         int               rows;
         int               n;
         cell_entry_type   c;
         param = '0;
         if (!mid) begin
            inst_b = INST_NONE;
            vol_b  = '0;
            cmd_b  = '0;
            if (b[7]) begin
               note_b = '0;
               mask   = b[MaskW-1:0];
            end else begin
               note_b = b;
               mask   = MASK_ALL_BUT_NOTE;
            end
         end else if (mask[0]) begin
            note_b  = b;
            mask[0] = 1'b0;
         end else if (mask[1]) begin
            inst_b  = b;
            mask[1] = 1'b0;
         end else if (mask[2]) begin
            vol_b   = b;
            mask[2] = 1'b0;
         end else if (mask[3]) begin
            cmd_b   = b;
            mask[3] = 1'b0;
         end else begin
            param = b;
            mask  = '0;
         end
         mid = (mask != '0);
         if (mid) return;

         // clamp the registers into their legal ranges
         chans = (chan_cfg == 0) ? 1 : int'(chan_cfg);
         if (chans > DefMaxChannels) chans = DefMaxChannels;
         rows = (row_cfg == 0) ? 1 : int'(row_cfg);
         if (rows > DefMaxRows) rows = DefMaxRows;

         // transpose into the output note range; bit 7 of the note is dropped
         n = int'(note_b[6:0]);
         if (n == 0)                        note_out = NOTE_NONE;
         else if (n == int'(NOTE_OFF_CODE)) note_out = NOTE_OFF;
         else if (n >= 30)                  note_out = ByteW'(n - 30);
         else if (n >= 18)                  note_out = ByteW'(n - 18);
         else if (n >= 6)                   note_out = ByteW'(n - 6);
         else                               note_out = ByteW'(n + 6);

         inst_out = (note_out == NOTE_OFF) ? INST_NONE : inst_b;
         vol_out  = (vol_b >= VOL_LOW && vol_b <= VOL_HIGH) ? 4 * (vol_b - VOL_LOW) : 0;

         c.note             = note_out;
         c.instrument       = inst_out;
         c.machine          = (note_out == NOTE_NONE && inst_out == INST_NONE && vol_out == 0
                               && cmd_b == 0 && param == 0) ? MACHINE_EMPTY : '0;
         c.volume           = VolumeW'(vol_out);
         c.effect_command   = cmd_b;
         c.effect_parameter = param;
         c.row              = RowW'(row_ctr);
         c.column           = ColumnW'(col_ctr);
         c.last_in_pattern  = (col_ctr == chans - 1 && row_ctr == rows - 1);
         due_cells.push_back(c);

         // a counter at or past a freshly lowered limit wraps on this advance
         col_ctr = col_ctr + 1;
         if (col_ctr >= chans) begin
            col_ctr = 0;
            row_ctr = row_ctr + 1;
            if (row_ctr >= rows) row_ctr = 0;
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= REPORT_CAP) $display("mismatch: %s", msg);
      endtask

      task compare_field(string name, cell_entry_type want, int got_v, int want_v);
         if (got_v != want_v) begin
            report($sformatf("row %0d col %0d %s got %0d expected %0d",
                             want.row, want.column, name, got_v, want_v));
         end
      endtask

      task check_cell(cell_entry_type got);
         cell_entry_type want;
         if (due_cells.size() == 0) begin
            report($sformatf("entry row %0d col %0d with none expected", got.row, got.column));
            return;
         end
         want = due_cells.pop_front();
         compare_field("note", want, got.note, want.note);
         compare_field("instrument", want, got.instrument, want.instrument);
         compare_field("machine", want, got.machine, want.machine);
         compare_field("volume", want, got.volume, want.volume);
         compare_field("effect_command", want, got.effect_command, want.effect_command);
         compare_field("effect_parameter", want, got.effect_parameter, want.effect_parameter);
         compare_field("row", want, got.row, want.row);
         compare_field("column", want, got.column, want.column);
         compare_field("last_in_pattern", want, got.last_in_pattern, want.last_in_pattern);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   tpcu_req_if req_if ();
   tpcu_rsp_if rsp_if ();
   tpcu_csr_if csr_if ();

   tracker_pattern_cell_unpacker u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   cell_ledger_type ledger;
   int         gap_pct;      // chance in percent of an idle burst before a byte
   int         stall_pct;    // chance in percent of a stall burst on the result side
   int         idle_cycles;

   always #1 clock = ~clock;

   // --- value pickers: bias toward band edges and the special codes ---

   function automatic logic [ByteW-1:0] pick_note();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return {1'($urandom_range(0, 1)), NOTE_OFF_CODE};
         2:       return ByteW'($urandom_range(1, 5));
         3:       return ByteW'($urandom_range(6, 17));
         4:       return ByteW'($urandom_range(18, 29));
         5:       return 8'h7f;
         default: return ByteW'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [ByteW-1:0] pick_volume();
      case ($urandom_range(0, 9))
         0:          return VOL_LOW - 8'd1;
         1:          return VOL_LOW;
         2:          return VOL_HIGH;
         3:          return VOL_HIGH + 8'd1;
         4, 5, 6:    return ByteW'($urandom_range(VOL_LOW, VOL_HIGH));
         default:    return ByteW'($urandom_range(0, 255));
      endcase
   endfunction

   // Instrument, command and parameter: often zero, sometimes all ones.
   function automatic logic [ByteW-1:0] pick_field();
      case ($urandom_range(0, 7))
         0, 1:    return 8'h00;
         2:       return 8'hff;
         default: return ByteW'($urandom_range(0, 255));
      endcase
   endfunction

   // --- drivers ---

   // Present one byte, maybe after an idle burst, and hold it until taken.
   task automatic push_byte(input logic [ByteW-1:0] b);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      ledger.take_byte(b);
   endtask

   // Build one cell. A sparse cell is mostly a lone empty mask, which walks
   // the pattern position at one byte per entry.
   task automatic send_cell(input bit sparse);
      logic [ByteW-1:0] head;
      logic [ByteW-1:0] nt;
      logic [ByteW-1:0] body [$];
      nt = pick_note();
      if (sparse && $urandom_range(0, 99) < 92) begin
         head = {1'b1, 2'($urandom_range(0, 3)), 5'd0};
      end else if ($urandom_range(0, 1) == 1) begin
         head = {1'b0, nt[6:0]};
         body.push_back(pick_field());
         body.push_back(pick_volume());
         body.push_back(pick_field());
         body.push_back(pick_field());
      end else begin
         head = {1'b1, 7'($urandom_range(0, 127))};
         if (head[0]) body.push_back(nt);
         if (head[1]) body.push_back(pick_field());
         if (head[2]) body.push_back(pick_volume());
         if (head[3]) body.push_back(pick_field());
         if (head[4]) body.push_back(pick_field());
      end
      push_byte(head);
      foreach (body[i]) push_byte(body[i]);
   endtask

   // Hold the write until the register port takes it. Valid is dropped by the
   // caller so back-to-back writes never lower and raise it in one step.
   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      ledger.write_reg(idx, val);
   endtask

   // Close the open cell, drain every owed entry, reprogram both registers,
   // then stream the given number of cells.
   task automatic run_phase(input logic [CsrDataW-1:0] chans_w, input logic [CsrDataW-1:0] rows_w,
                            input int cells, input bit sparse, input int idle_pct);
      while (ledger.mid) push_byte(ByteW'($urandom_range(0, 255)));
      req_if.valid <= 1'b0;
      while (ledger.due_cells.size() != 0) @(posedge clock);
      // let the output register stage go quiet before touching registers
      repeat (3) @(posedge clock);
      write_csr(CSR_CHANNEL_COUNT, chans_w);
      write_csr(CSR_ROW_COUNT, rows_w);
      csr_if.valid <= 1'b0;
      gap_pct   = idle_pct;
      stall_pct = idle_pct;
      for (int i = 0; i < cells; i++) begin
         // stray raw bytes: any byte is legal, so noise just opens odd cells
         if (!sparse && $urandom_range(0, 9) == 0) push_byte(ByteW'($urandom_range(0, 255)));
         else send_cell(sparse);
      end
   endtask

   // --- result side: random stall bursts, checking of every taken word ---

   initial begin
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cell_entry_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.note             = rsp_if.note;
         got.instrument       = rsp_if.instrument;
         got.machine          = rsp_if.machine;
         got.volume           = rsp_if.volume;
         got.effect_command   = rsp_if.effect_command;
         got.effect_parameter = rsp_if.effect_parameter;
         got.row              = rsp_if.row;
         got.column           = rsp_if.column;
         got.last_in_pattern  = rsp_if.last_in_pattern;
         ledger.check_cell(got);
      end
   end

   // --- watchdog: count cycles in which no word moves anywhere ---

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // --- main sequence ---

   initial begin
      ledger    = new();
      gap_pct   = 0;
      stall_pct = 0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= CSR_CHANNEL_COUNT;
      csr_if.data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // opening cells run on the reset register values, no idling
      for (int i = 0; i < $size(OPENING); i++) push_byte(OPENING[i]);

      // one channel, one row: every cell is the last of its pattern
      run_phase(9'd1, 9'd1, 8, 1'b0, 20);
      // zero in both registers counts as one
      run_phase(9'd0, 9'd0, 6, 1'b0, 35);
      // all data bits set on the channel register: 127 clamps to 64; walk
      // past column 63
      run_phase(9'h1ff, 9'd2, 66, 1'b1, 10);
      // shrink mid-pattern: the column stands past the new limit and wraps
      run_phase(9'd2, 9'd3, 10, 1'b0, 25);
      // a full 256-row pattern on one channel reaches row 255
      run_phase(9'd1, 9'h100, 258, 1'b1, 5);
      // all bits set on the row register: 511 clamps to 256
      run_phase(9'd3, 9'h1ff, 10, 1'b0, 30);
      // just above both maximums
      run_phase(9'd65, 9'd257, 6, 1'b0, 15);
      // small random patterns with varied idling
      repeat (3) begin
         run_phase(CsrDataW'($urandom_range(1, 6)), CsrDataW'($urandom_range(1, 4)), 10, 1'b0,
                   $urandom_range(0, 40));
      end
      // tail with no idling on either side
      run_phase(CsrDataW'($urandom_range(1, 4)), CsrDataW'($urandom_range(1, 3)), 12, 1'b0, 0);

      // close any open cell, then drain
      while (ledger.mid) push_byte(ByteW'($urandom_range(0, 255)));
      req_if.valid <= 1'b0;
      while (ledger.due_cells.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (ledger.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
